>>> hw/rtl/tbims_pkg.sv
// Shared types and constants for the two-body invariant mass selector.
// Used by the controller, the datapath, the top level and the port checker.
// Depends on nothing.
package tbims_pkg;

	// Result status codes.
	localparam logic [2:0] ST_ACCEPT  = 3'd0;
	localparam logic [2:0] ST_OUTSIDE = 3'd1;
	localparam logic [2:0] ST_COUNT   = 3'd2;
	localparam logic [2:0] ST_CHARGE  = 3'd3;
	localparam logic [2:0] ST_PAIR    = 3'd4;
	localparam logic [2:0] ST_NEGSQ   = 3'd5;
	localparam logic [2:0] ST_TIE     = 3'd6;

	// Configuration register indexes.
	localparam logic [2:0] REG_PION_MASS   = 3'd0;
	localparam logic [2:0] REG_PROTON_MASS = 3'd1;
	localparam logic [2:0] REG_KAON_REF    = 3'd2;
	localparam logic [2:0] REG_LAMBDA_REF  = 3'd3;
	localparam logic [2:0] REG_WIN_LOW     = 3'd4;
	localparam logic [2:0] REG_WIN_HIGH    = 3'd5;

	// Configuration reset values.
	localparam logic [31:0] RST_PION_MASS   = 32'd9147;
	localparam logic [31:0] RST_PROTON_MASS = 32'd61490;
	localparam logic [31:0] RST_KAON_REF    = 32'd32611;
	localparam logic [31:0] RST_LAMBDA_REF  = 32'd73117;
	localparam logic [31:0] RST_WIN_LOW     = 32'd0;
	localparam logic [31:0] RST_WIN_HIGH    = 32'hFFFF_FFFF;

	// Squarer operand selection.
	localparam logic [3:0] SQ_PX     = 4'd0;
	localparam logic [3:0] SQ_PY     = 4'd1;
	localparam logic [3:0] SQ_PZ     = 4'd2;
	localparam logic [3:0] SQ_PION   = 4'd3;
	localparam logic [3:0] SQ_PROTON = 4'd4;
	localparam logic [3:0] SQ_SX     = 4'd5;
	localparam logic [3:0] SQ_SY     = 4'd6;
	localparam logic [3:0] SQ_SZ     = 4'd7;
	localparam logic [3:0] SQ_EK     = 4'd8;
	localparam logic [3:0] SQ_EL     = 4'd9;
	localparam logic [3:0] SQ_MASS   = 4'd10;

	// Momentum-square accumulator operations.
	localparam logic [1:0] P2_HOLD = 2'd0;
	localparam logic [1:0] P2_LOAD = 2'd1;
	localparam logic [1:0] P2_ACC  = 2'd2;

	// Square root operand sources.
	localparam logic [1:0] RT_ENERGY = 2'd0;
	localparam logic [1:0] RT_KDIFF  = 2'd1;
	localparam logic [1:0] RT_LDIFF  = 2'd2;

	typedef struct packed {
		logic       load_item;
		logic       sq_en;
		logic [3:0] sq_sel;
		logic [1:0] p2_op;
		logic       root_start;
		logic [1:0] root_src;
		logic       add_pion;
		logic       add_proton;
		logic       ek2_load;
		logic       diff_load;
		logic       mk_load;
		logic       ml_load;
		logic       decide_load;
		logic       acc_update;
		logic       status_load;
		logic [2:0] status_val;
		logic       out_load;
	} tbims_cmd_t;

	typedef struct packed {
		logic       root_done;
		logic       charge_pos;
		logic       last;
		logic [2:0] early_status;
		logic       mass_neg;
		logic       tie;
		logic       outside;
		logic       out_free;
	} tbims_stat_t;

endpackage

>>> hw/rtl/tbims_root.sv
// Iterative integer square root, floor(sqrt(x)) of a 64-bit value.
// One result bit per cycle. Depends on nothing.
module tbims_root (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] operand,
	output logic        done,
	output logic [31:0] root
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [63:0] x_q;
	logic [33:0] rem_q;
	logic [31:0] root_q;
	logic [35:0] rem_sh;
	logic [35:0] trial;
	logic        fits;

	assign rem_sh = {rem_q, x_q[63:62]};
	assign trial  = {2'b00, root_q, 2'b01};
	assign fits   = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= operand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q <= {x_q[61:0], 2'b00};
			if (fits) begin
				rem_q  <= 34'(rem_sh - trial);
				root_q <= {root_q[30:0], 1'b1};
			end else begin
				rem_q  <= rem_sh[33:0];
				root_q <= {root_q[30:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

>>> hw/rtl/tbims_datapath.sv
// Datapath of the mass selector: configuration, event sums, squarer,
// square root unit, decision logic, accumulators and the result register.
// Depends on tbims_pkg and tbims_root.
module tbims_datapath import tbims_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic signed [7:0]  charge,
	input  logic signed [27:0] mom_x,
	input  logic signed [27:0] mom_y,
	input  logic signed [27:0] mom_z,
	input  logic               last_of_event,
	input  tbims_cmd_t         cmd,
	output tbims_stat_t        stat,
	input  logic               out_stall,
	output logic               out_valid,
	output logic [2:0]         status,
	output logic               hypothesis,
	output logic [29:0]        mass_value,
	output logic [47:0]        mass_total,
	output logic [63:0]        mass_square_total
);

	logic [31:0] pion_q, proton_q, kref_q, lref_q, wlow_q, whigh_q;

	logic signed [7:0] charge_q;
	logic [27:0] ax_q, ay_q, az_q;
	logic        last_q;
	logic [1:0]  pcnt_q, poscnt_q, negcnt_q;
	logic        cerr_q;
	logic signed [28:0] sx_q, sy_q, sz_q;
	logic [29:0] ek_q, el_q;
	logic [47:0] msum_q;
	logic [63:0] sqsum_q;

	logic [31:0] sq_in;
	logic [63:0] prod_q, p2_q, ek2_q, kdiff_q, ldiff_q;
	logic [29:0] mk_q, ml_q, m_q;
	logic        hyp_q, tie_q;
	logic [2:0]  status_q;

	logic        out_valid_q;
	logic [2:0]  out_status_q;
	logic        out_hyp_q;
	logic [29:0] out_mass_q;
	logic [47:0] out_total_q;
	logic [63:0] out_sq_q;

	logic        rt_done;
	logic [31:0] rt_root;
	logic [63:0] rt_operand;
	logic [64:0] e2_sum;
	logic [32:0] dk, dl;
	logic        is_pos, is_neg;

	function automatic logic [28:0] mag29(input logic signed [28:0] v);
		return v[28] ? 29'(-v) : 29'(v);
	endfunction

	function automatic logic [27:0] mag28(input logic signed [27:0] v);
		return v[27] ? 28'(-v) : 28'(v);
	endfunction

	function automatic logic [29:0] add_energy(input logic [29:0] acc, input logic [31:0] e);
		logic [32:0] s;
		s = {3'b000, acc} + {1'b0, e};
		return (s > 33'h3FFF_FFFF) ? 30'h3FFF_FFFF : s[29:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pion_q   <= RST_PION_MASS;
			proton_q <= RST_PROTON_MASS;
			kref_q   <= RST_KAON_REF;
			lref_q   <= RST_LAMBDA_REF;
			wlow_q   <= RST_WIN_LOW;
			whigh_q  <= RST_WIN_HIGH;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PION_MASS:   pion_q   <= cfg_data;
				REG_PROTON_MASS: proton_q <= cfg_data;
				REG_KAON_REF:    kref_q   <= cfg_data;
				REG_LAMBDA_REF:  lref_q   <= cfg_data;
				REG_WIN_LOW:     wlow_q   <= cfg_data;
				REG_WIN_HIGH:    whigh_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign is_pos = (charge_q == 8'sd1);
	assign is_neg = (charge_q == -8'sd1);

	// Per-event state, accumulators and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcnt_q      <= '0;
			poscnt_q    <= '0;
			negcnt_q    <= '0;
			cerr_q      <= 1'b0;
			sx_q        <= '0;
			sy_q        <= '0;
			sz_q        <= '0;
			ek_q        <= '0;
			el_q        <= '0;
			msum_q      <= '0;
			sqsum_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_item) begin
				if (pcnt_q != 2'd3) pcnt_q <= pcnt_q + 2'd1;
				if (charge == 8'sd1) begin
					if (poscnt_q != 2'd3) poscnt_q <= poscnt_q + 2'd1;
				end else if (charge == -8'sd1) begin
					if (negcnt_q != 2'd3) negcnt_q <= negcnt_q + 2'd1;
				end else begin
					cerr_q <= 1'b1;
				end
				sx_q <= sx_q + 29'(mom_x);
				sy_q <= sy_q + 29'(mom_y);
				sz_q <= sz_q + 29'(mom_z);
			end
			if (cmd.add_pion) begin
				ek_q <= add_energy(ek_q, rt_root);
				if (is_neg) el_q <= add_energy(el_q, rt_root);
			end
			if (cmd.add_proton) el_q <= add_energy(el_q, rt_root);
			if (cmd.acc_update) begin
				msum_q  <= ((49'(msum_q) + 49'(m_q)) > 49'hFFFF_FFFF_FFFF) ?
					48'hFFFF_FFFF_FFFF : 48'(msum_q + 48'(m_q));
				sqsum_q <= ((65'(sqsum_q) + 65'(prod_q)) > 65'hFFFF_FFFF_FFFF_FFFF) ?
					64'hFFFF_FFFF_FFFF_FFFF : sqsum_q + prod_q;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
				pcnt_q      <= '0;
				poscnt_q    <= '0;
				negcnt_q    <= '0;
				cerr_q      <= 1'b0;
				sx_q        <= '0;
				sy_q        <= '0;
				sz_q        <= '0;
				ek_q        <= '0;
				el_q        <= '0;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		case (cmd.sq_sel)
			SQ_PX:     sq_in = 32'(ax_q);
			SQ_PY:     sq_in = 32'(ay_q);
			SQ_PZ:     sq_in = 32'(az_q);
			SQ_PION:   sq_in = pion_q;
			SQ_PROTON: sq_in = proton_q;
			SQ_SX:     sq_in = 32'(mag29(sx_q));
			SQ_SY:     sq_in = 32'(mag29(sy_q));
			SQ_SZ:     sq_in = 32'(mag29(sz_q));
			SQ_EK:     sq_in = 32'(ek_q);
			SQ_EL:     sq_in = 32'(el_q);
			SQ_MASS:   sq_in = 32'(m_q);
			default:   sq_in = '0;
		endcase
	end

	assign e2_sum = {1'b0, p2_q} + {1'b0, prod_q};

	always_comb begin
		case (cmd.root_src)
			RT_KDIFF: rt_operand = kdiff_q;
			RT_LDIFF: rt_operand = ldiff_q;
			default:  rt_operand = e2_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : e2_sum[63:0];
		endcase
	end

	assign dk = ({2'b00, mk_q} > {1'b0, kref_q}) ? 33'({2'b00, mk_q}) - {1'b0, kref_q}
	                                             : {1'b0, kref_q} - 33'({2'b00, mk_q});
	assign dl = ({2'b00, ml_q} > {1'b0, lref_q}) ? 33'({2'b00, ml_q}) - {1'b0, lref_q}
	                                             : {1'b0, lref_q} - 33'({2'b00, ml_q});

	// Payload registers: no reset needed.
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			charge_q <= charge;
			ax_q     <= mag28(mom_x);
			ay_q     <= mag28(mom_y);
			az_q     <= mag28(mom_z);
			last_q   <= last_of_event;
		end
		if (cmd.sq_en) prod_q <= {32'd0, sq_in} * {32'd0, sq_in};
		case (cmd.p2_op)
			P2_LOAD: p2_q <= prod_q;
			P2_ACC:  p2_q <= p2_q + prod_q;
			default: ;
		endcase
		if (cmd.ek2_load) ek2_q <= prod_q;
		if (cmd.diff_load) begin
			kdiff_q <= ek2_q - p2_q;
			ldiff_q <= prod_q - p2_q;
		end
		if (cmd.mk_load) mk_q <= rt_root[29:0];
		if (cmd.ml_load) ml_q <= rt_root[29:0];
		if (cmd.decide_load) begin
			tie_q <= (dk == dl);
			hyp_q <= !(dk < dl);
			m_q   <= (dk < dl) ? mk_q : ml_q;
		end
		if (cmd.status_load) status_q <= cmd.status_val;
		if (cmd.out_load) begin
			out_status_q <= status_q;
			out_hyp_q    <= (status_q == ST_ACCEPT || status_q == ST_OUTSIDE) ? hyp_q : 1'b0;
			out_mass_q   <= (status_q == ST_ACCEPT) ? m_q : '0;
			out_total_q  <= msum_q;
			out_sq_q     <= sqsum_q;
		end
	end

	tbims_root u_root (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.root_start),
		.operand (rt_operand),
		.done    (rt_done),
		.root    (rt_root)
	);

	always_comb begin
		stat.root_done  = rt_done;
		stat.charge_pos = is_pos;
		stat.last       = last_q;
		if (pcnt_q != 2'd2)                        stat.early_status = ST_COUNT;
		else if (cerr_q)                           stat.early_status = ST_CHARGE;
		else if (poscnt_q != 2'd1 || negcnt_q != 2'd1) stat.early_status = ST_PAIR;
		else                                       stat.early_status = ST_ACCEPT;
		stat.mass_neg = (prod_q < p2_q) || (ek2_q < p2_q);
		stat.tie      = tie_q;
		stat.outside  = ({2'b00, m_q} < wlow_q) || ({2'b00, m_q} > whigh_q);
		stat.out_free = !out_valid_q || !out_stall;
	end

	assign out_valid         = out_valid_q;
	assign status            = out_status_q;
	assign hypothesis        = out_hyp_q;
	assign mass_value        = out_mass_q;
	assign mass_total        = out_total_q;
	assign mass_square_total = out_sq_q;

endmodule

>>> hw/rtl/tbims_ctrl.sv
// Sequencing state machine of the mass selector.
// Drives datapath commands from datapath status. Depends on tbims_pkg.
module tbims_ctrl import tbims_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  tbims_stat_t stat,
	output tbims_cmd_t  cmd
);

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_PX   = 5'd1;
	localparam logic [4:0] S_PY   = 5'd2;
	localparam logic [4:0] S_PZ   = 5'd3;
	localparam logic [4:0] S_PM   = 5'd4;
	localparam logic [4:0] S_RPI  = 5'd5;
	localparam logic [4:0] S_WPI  = 5'd6;
	localparam logic [4:0] S_PP   = 5'd7;
	localparam logic [4:0] S_RPR  = 5'd8;
	localparam logic [4:0] S_WPR  = 5'd9;
	localparam logic [4:0] S_CHK  = 5'd10;
	localparam logic [4:0] S_SY   = 5'd11;
	localparam logic [4:0] S_SZ   = 5'd12;
	localparam logic [4:0] S_EK   = 5'd13;
	localparam logic [4:0] S_EL   = 5'd14;
	localparam logic [4:0] S_NEG  = 5'd15;
	localparam logic [4:0] S_RK   = 5'd16;
	localparam logic [4:0] S_WK   = 5'd17;
	localparam logic [4:0] S_RL   = 5'd18;
	localparam logic [4:0] S_WL   = 5'd19;
	localparam logic [4:0] S_DEC  = 5'd20;
	localparam logic [4:0] S_WIN  = 5'd21;
	localparam logic [4:0] S_ACC  = 5'd22;
	localparam logic [4:0] S_OUT  = 5'd23;

	logic [4:0] state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d = S_PX;
				end
			end
			S_PX: begin
				cmd.sq_en = 1'b1; cmd.sq_sel = SQ_PX;
				state_d = S_PY;
			end
			S_PY: begin
				cmd.p2_op = P2_LOAD; cmd.sq_en = 1'b1; cmd.sq_sel = SQ_PY;
				state_d = S_PZ;
			end
			S_PZ: begin
				cmd.p2_op = P2_ACC; cmd.sq_en = 1'b1; cmd.sq_sel = SQ_PZ;
				state_d = S_PM;
			end
			S_PM: begin
				cmd.p2_op = P2_ACC; cmd.sq_en = 1'b1; cmd.sq_sel = SQ_PION;
				state_d = S_RPI;
			end
			S_RPI: begin
				cmd.root_start = 1'b1; cmd.root_src = RT_ENERGY;
				state_d = S_WPI;
			end
			S_WPI: begin
				if (stat.root_done) begin
					cmd.add_pion = 1'b1;
					if (stat.charge_pos) state_d = S_PP;
					else if (stat.last)  state_d = S_CHK;
					else                 state_d = S_IDLE;
				end
			end
			S_PP: begin
				cmd.sq_en = 1'b1; cmd.sq_sel = SQ_PROTON;
				state_d = S_RPR;
			end
			S_RPR: begin
				cmd.root_start = 1'b1; cmd.root_src = RT_ENERGY;
				state_d = S_WPR;
			end
			S_WPR: begin
				if (stat.root_done) begin
					cmd.add_proton = 1'b1;
					state_d = stat.last ? S_CHK : S_IDLE;
				end
			end
			S_CHK: begin
				if (stat.early_status != ST_ACCEPT) begin
					cmd.status_load = 1'b1; cmd.status_val = stat.early_status;
					state_d = S_OUT;
				end else begin
					cmd.sq_en = 1'b1; cmd.sq_sel = SQ_SX;
					state_d = S_SY;
				end
			end
			S_SY: begin
				cmd.p2_op = P2_LOAD; cmd.sq_en = 1'b1; cmd.sq_sel = SQ_SY;
				state_d = S_SZ;
			end
			S_SZ: begin
				cmd.p2_op = P2_ACC; cmd.sq_en = 1'b1; cmd.sq_sel = SQ_SZ;
				state_d = S_EK;
			end
			S_EK: begin
				cmd.p2_op = P2_ACC; cmd.sq_en = 1'b1; cmd.sq_sel = SQ_EK;
				state_d = S_EL;
			end
			S_EL: begin
				cmd.ek2_load = 1'b1; cmd.sq_en = 1'b1; cmd.sq_sel = SQ_EL;
				state_d = S_NEG;
			end
			S_NEG: begin
				if (stat.mass_neg) begin
					cmd.status_load = 1'b1; cmd.status_val = ST_NEGSQ;
					state_d = S_OUT;
				end else begin
					cmd.diff_load = 1'b1;
					state_d = S_RK;
				end
			end
			S_RK: begin
				cmd.root_start = 1'b1; cmd.root_src = RT_KDIFF;
				state_d = S_WK;
			end
			S_WK: begin
				if (stat.root_done) begin
					cmd.mk_load = 1'b1;
					state_d = S_RL;
				end
			end
			S_RL: begin
				cmd.root_start = 1'b1; cmd.root_src = RT_LDIFF;
				state_d = S_WL;
			end
			S_WL: begin
				if (stat.root_done) begin
					cmd.ml_load = 1'b1;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				cmd.decide_load = 1'b1;
				state_d = S_WIN;
			end
			S_WIN: begin
				if (stat.tie) begin
					cmd.status_load = 1'b1; cmd.status_val = ST_TIE;
					state_d = S_OUT;
				end else if (stat.outside) begin
					cmd.status_load = 1'b1; cmd.status_val = ST_OUTSIDE;
					state_d = S_OUT;
				end else begin
					cmd.sq_en = 1'b1; cmd.sq_sel = SQ_MASS;
					state_d = S_ACC;
				end
			end
			S_ACC: begin
				cmd.acc_update = 1'b1;
				cmd.status_load = 1'b1; cmd.status_val = ST_ACCEPT;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

>>> hw/rtl/two_body_invariant_mass_select.sv
// Two-body invariant mass selector: top level joining controller and datapath.
// Depends on tbims_pkg, tbims_ctrl and tbims_datapath.
//
// Each input item is one decay product: an 8-bit signed charge, a Q12.16
// momentum vector and a flag that marks the last product of an event. Items
// that do not close an event produce no result. The closing item produces
// exactly one result, carrying a status code, the chosen hypothesis (kaon
// from two pions, or lambda from a proton and a pion), the chosen invariant
// mass and the saturating sum and sum of squares of all masses accepted so
// far. The block works on one item at a time. An item with negative charge
// (or an illegal charge) needs one energy square root and one with positive
// charge needs two; a closing item that passes the particle checks and the
// mass square sign check also needs the two mass square roots. The run time
// is set by the single shared square root unit, which resolves one result
// bit per cycle, and by the one 32 by 32 squarer that is used in turn for
// every product. A finished result sits in an output register, so the next
// item is taken while the result waits; only a second closing item waits
// for it to drain. Configuration registers are written through a plain
// write port and should only be changed while the block is idle; unknown
// indexes are ignored.
module two_body_invariant_mass_select import tbims_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [7:0]  charge,
	input  logic signed [27:0] mom_x,
	input  logic signed [27:0] mom_y,
	input  logic signed [27:0] mom_z,
	input  logic               last_of_event,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         status,
	output logic               hypothesis,
	output logic [29:0]        mass_value,
	output logic [47:0]        mass_total,
	output logic [63:0]        mass_square_total
);

	tbims_cmd_t  cmd;
	tbims_stat_t stat;

	// The controller sequences every item through the shared arithmetic.
	tbims_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// The datapath holds the configuration, the event sums, the squarer,
	// the square root unit, the accumulators and the result register.
	tbims_datapath u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.charge            (charge),
		.mom_x             (mom_x),
		.mom_y             (mom_y),
		.mom_z             (mom_z),
		.last_of_event     (last_of_event),
		.cmd               (cmd),
		.stat              (stat),
		.out_stall         (out_stall),
		.out_valid         (out_valid),
		.status            (status),
		.hypothesis        (hypothesis),
		.mass_value        (mass_value),
		.mass_total        (mass_total),
		.mass_square_total (mass_square_total)
	);

endmodule

>>> hw/rtl/tbims_checker.sv
// Port-level checks for the two-body invariant mass selector, and the bind
// that attaches them to the top level. Depends on tbims_pkg.
module tbims_checker import tbims_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  status,
	input logic        hypothesis,
	input logic [29:0] mass_value
);

	// A result waits while the receiver stalls.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// Every item holds off the next: the block stalls once it has taken one.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("item taken without holding off the next");

	// Only an accepted event carries a mass.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_ACCEPT |-> mass_value == 30'd0)
		else $error("mass shown on a rejected event");

	// Hypothesis is only meaningful once a mass was chosen.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_ACCEPT && status != ST_OUTSIDE |-> !hypothesis)
		else $error("hypothesis set on an early rejection");

endmodule

bind two_body_invariant_mass_select tbims_checker u_tbims_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.status     (status),
	.hypothesis (hypothesis),
	.mass_value (mass_value)
);

>>> tb/sv/tb.sv
// Testbench for the two-body invariant mass selector.
// Depends on tbims_pkg and two_body_invariant_mass_select; self-checking with
// its own bit-true prediction of the event close, the hypothesis choice and the totals.
module tb;
	import tbims_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// Clock, reset and the block's ports.
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [7:0] charge = '0;
	logic signed [27:0] mom_x = '0, mom_y = '0, mom_z = '0;
	logic last_of_event = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [2:0] status;
	logic hypothesis;
	logic [29:0] mass_value;
	logic [47:0] mass_total;
	logic [63:0] mass_square_total;

	always #6 clk = ~clk;

	two_body_invariant_mass_select dut (.*);

	// One expected event result.
	typedef struct {
		logic [2:0] st;
		logic hyp;
		logic [29:0] mass;
		logic [47:0] tot;
		logic [63:0] sqtot;
	} event_result_t;

	event_result_t pending_events[$];
	int errors = 0;
	int items_sent = 0;
	int events_seen = 0;
	int accepted_seen = 0;

	// Predictor state: a copy of the configuration registers and the event sums.
	logic [31:0] m_pion, m_proton, ref_kaon, ref_lambda, win_lo, win_hi;
	logic [1:0] n_part, n_pos, n_neg;
	logic bad_q;
	logic signed [28:0] sx, sy, sz;
	logic [29:0] e_kaon, e_lambda;
	logic [47:0] acc_mass;
	logic [63:0] acc_square;

	function automatic logic [63:0] root_floor(logic [63:0] x);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic logic [63:0] add_sat64(logic [63:0] a, logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? '1 : s[63:0];
	endfunction

	function automatic logic [63:0] abs_of(logic signed [63:0] v);
		return v < 0 ? -v : v;
	endfunction

	// Energy of one product, added to an energy sum that saturates at 30 bits.
	function automatic logic [29:0] energy_add(logic [29:0] acc, logic [63:0] p2,
			logic [31:0] m);
		logic [63:0] e, s;
		e = root_floor(add_sat64(p2, 64'(m) * 64'(m)));
		s = 64'(acc) + e;
		return s > 64'h3FFF_FFFF ? 30'h3FFF_FFFF : s[29:0];
	endfunction

	task automatic clear_event_sums();
		n_part = 0; n_pos = 0; n_neg = 0; bad_q = 0;
		sx = 0; sy = 0; sz = 0; e_kaon = 0; e_lambda = 0;
	endtask

	task automatic predict_product(logic signed [7:0] q, logic signed [27:0] x,
			logic signed [27:0] y, logic signed [27:0] z, logic last);
		logic [63:0] p2, sp2, ek2, el2, mk, ml, dk, dl, m, s;
		event_result_t r;
		p2 = abs_of(x) * abs_of(x) + abs_of(y) * abs_of(y) + abs_of(z) * abs_of(z);
		if (n_part < 3) n_part++;
		sx = sx + x; sy = sy + y; sz = sz + z;
		e_kaon = energy_add(e_kaon, p2, m_pion);
		if (q == 1) begin
			if (n_pos < 3) n_pos++;
			e_lambda = energy_add(e_lambda, p2, m_proton);
		end else if (q == -1) begin
			if (n_neg < 3) n_neg++;
			e_lambda = energy_add(e_lambda, p2, m_pion);
		end else begin
			bad_q = 1;
		end
		if (!last) return;
		r.hyp = 0; r.mass = 0;
		if (n_part != 2) r.st = ST_COUNT;
		else if (bad_q) r.st = ST_CHARGE;
		else if (n_pos != 1 || n_neg != 1) r.st = ST_PAIR;
		else begin
			sp2 = abs_of(sx) * abs_of(sx) + abs_of(sy) * abs_of(sy)
				+ abs_of(sz) * abs_of(sz);
			ek2 = 64'(e_kaon) * 64'(e_kaon);
			el2 = 64'(e_lambda) * 64'(e_lambda);
			if (ek2 < sp2 || el2 < sp2) r.st = ST_NEGSQ;
			else begin
				mk = root_floor(ek2 - sp2);
				ml = root_floor(el2 - sp2);
				dk = mk > ref_kaon ? mk - ref_kaon : ref_kaon - mk;
				dl = ml > ref_lambda ? ml - ref_lambda : ref_lambda - ml;
				if (dk == dl) r.st = ST_TIE;
				else begin
					r.hyp = dk < dl ? 1'b0 : 1'b1;
					m = r.hyp ? ml : mk;
					if (m < win_lo || m > win_hi) r.st = ST_OUTSIDE;
					else begin
						r.st = ST_ACCEPT;
						s = 64'(acc_mass) + m;
						acc_mass = s > 64'hFFFF_FFFF_FFFF ? '1 : s[47:0];
						acc_square = add_sat64(acc_square, m * m);
						r.mass = m[29:0];
					end
				end
			end
		end
		r.tot = acc_mass;
		r.sqtot = acc_square;
		pending_events.push_back(r);
		clear_event_sums();
	endtask

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch on %s at %0t: got %0h, expected %0h", what, $realtime, got, want);
		errors++;
	endtask

	// Result checker; the receiver stalls in runs whose density changes over time.
	int stall_mode = 0;
	always @(posedge clk) begin
		event_result_t w;
		if (arst_n && out_valid && !out_stall) begin
			events_seen++;
			if (pending_events.size() == 0) begin
				$display("unexpected result at %0t", $realtime);
				errors++;
			end else begin
				w = pending_events.pop_front();
				if (status == ST_ACCEPT) accepted_seen++;
				if (status !== w.st) report_mismatch("status", status, w.st);
				if (hypothesis !== w.hyp) report_mismatch("hypothesis", hypothesis, w.hyp);
				if (mass_value !== w.mass) report_mismatch("mass_value", mass_value, w.mass);
				if (mass_total !== w.tot) report_mismatch("mass_total", mass_total, w.tot);
				if (mass_square_total !== w.sqtot)
					report_mismatch("mass_square_total", mass_square_total, w.sqtot);
			end
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			default: out_stall <= ($urandom_range(0, 9) < 7);
		endcase
		if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
	end

	// Sender bursts: a random gap is taken between bursts of random length.
	int burst_left = 0;

	task automatic send_product(logic signed [7:0] q, logic signed [27:0] x,
			logic signed [27:0] y, logic signed [27:0] z, logic last);
		if (burst_left == 0) begin
			repeat ($urandom_range(0, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 8);
		end
		burst_left--;
		in_valid <= 1'b1;
		charge <= q; mom_x <= x; mom_y <= y; mom_z <= z; last_of_event <= last;
		do @(posedge clk); while (in_stall);
		predict_product(q, x, y, z, last);
		items_sent++;
		// The block holds off the next item after taking one,
		// so this cycle with valid low costs nothing.
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (pending_events.size() != 0) @(posedge clk);
		// A non-closing item may still be in flight; allow its longest run.
		repeat (200) @(posedge clk);
	endtask

	task automatic write_register(logic [2:0] idx, logic [31:0] v);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_PION_MASS:   m_pion = v;
			REG_PROTON_MASS: m_proton = v;
			REG_KAON_REF:    ref_kaon = v;
			REG_LAMBDA_REF:  ref_lambda = v;
			REG_WIN_LOW:     win_lo = v;
			REG_WIN_HIGH:    win_hi = v;
			default: ;
		endcase
	endtask

	function automatic logic signed [27:0] rand_mom();
		case ($urandom_range(0, 5))
			0: return 28'sh7FFFFFF;
			1: return 28'sh8000000;
			2: return 28'($urandom);
			default: return 28'($signed($urandom_range(0, 400000)) - 200000);
		endcase
	endfunction

	// A well-formed pair of opposite charges, in random order.
	task automatic send_pair();
		logic first_pos;
		first_pos = $urandom_range(0, 1);
		send_product(first_pos ? 8'sd1 : -8'sd1, rand_mom(), rand_mom(), rand_mom(), 0);
		send_product(first_pos ? -8'sd1 : 8'sd1, rand_mom(), rand_mom(), rand_mom(), 1);
	endtask

	// Directed: field extremes, the count, charge and pair rejections, a tie and an inverted window.
	task automatic test_directed();
		send_product(8'sd1, 28'sd0, 28'sd0, 28'sd0, 1);                 // count of one
		send_product(8'sd1, 28'sh7FFFFFF, 28'sh7FFFFFF, 28'sh7FFFFFF, 0);
		send_product(-8'sd1, 28'sh8000000, 28'sh8000000, 28'sh8000000, 1);
		send_product(8'sd1, 28'sd100, 28'sd0, 28'sd0, 0);               // three products
		send_product(-8'sd1, 28'sd0, 28'sd100, 28'sd0, 0);
		send_product(-8'sd1, 28'sd0, 28'sd0, 28'sd100, 1);
		send_product(8'sh7F, 28'sd5, 28'sd5, 28'sd5, 0);                // illegal charge
		send_product(-8'sd1, 28'sd5, 28'sd5, 28'sd5, 1);
		send_product(8'sh80, 28'sd0, 28'sd0, 28'sd0, 0);
		send_product(8'sd0, 28'sd0, 28'sd0, 28'sd0, 1);
		send_product(8'sd1, 28'sd70000, 28'sd0, 28'sd0, 0);             // same charges
		send_product(8'sd1, -28'sd70000, 28'sd0, 28'sd0, 1);
		send_product(8'sd1, 28'sd65536, 28'sd20000, -28'sd3000, 0);     // ordinary pair
		send_product(-8'sd1, -28'sd30000, 28'sd9000, 28'sd65536, 1);
		send_product(-8'sd1, 28'sh7FFFFFF, 28'sd0, 28'sd0, 0);
		send_product(8'sd1, 28'sh7FFFFFF, 28'sd0, 28'sd0, 1);
		wait_drained();
		// Zero masses at rest: a zero-distance tie when both references are zero.
		write_register(REG_PION_MASS, 32'd0);
		write_register(REG_PROTON_MASS, 32'd0);
		write_register(REG_KAON_REF, 32'd0);
		write_register(REG_LAMBDA_REF, 32'd0);
		send_product(8'sd1, 28'sd0, 28'sd0, 28'sd0, 0);
		send_product(-8'sd1, 28'sd0, 28'sd0, 28'sd0, 1);
		// Opposite momenta: a negative mass square is not possible, a back-to-back pair is.
		send_product(8'sd1, 28'sd1000, 28'sd0, 28'sd0, 0);
		send_product(-8'sd1, -28'sd1000, 28'sd0, 28'sd0, 1);
		wait_drained();
		write_register(REG_PION_MASS, 32'hFFFF_FFFF);                   // saturating energy
		write_register(REG_PROTON_MASS, 32'hFFFF_FFFF);
		write_register(REG_KAON_REF, 32'hFFFF_FFFF);
		write_register(REG_LAMBDA_REF, 32'd1);
		write_register(REG_WIN_LOW, 32'd10);                            // inverted window
		write_register(REG_WIN_HIGH, 32'd5);
		send_pair();
		send_pair();
		wait_drained();
	endtask

	task automatic test_random_settings();
		for (int phase = 0; phase < 6; phase++) begin
			write_register(REG_PION_MASS, phase == 0 ? RST_PION_MASS : $urandom_range(0, 200000));
			write_register(REG_PROTON_MASS, phase == 0 ? RST_PROTON_MASS :
				$urandom_range(0, 400000));
			write_register(REG_KAON_REF, phase == 5 ? 32'hFFFF_FFFF : $urandom_range(0, 300000));
			write_register(REG_LAMBDA_REF, phase == 4 ? 32'd0 : $urandom_range(0, 600000));
			write_register(REG_WIN_LOW, phase < 2 ? 32'd0 : $urandom_range(0, 50000));
			write_register(REG_WIN_HIGH, phase < 2 ? 32'hFFFF_FFFF :
				$urandom_range(50000, 3000000));
			write_register(3'd7, $urandom);                             // unknown index
			for (int k = 0; k < 38; k++) begin
				if ($urandom_range(0, 9) < 8) send_pair();
				else send_product(8'($urandom), rand_mom(), rand_mom(), rand_mom(),
					$urandom_range(0, 1));
			end
			wait_drained();
		end
	endtask

	// The accumulators persist: restore the defaults and push a few wide-open events.
	task automatic test_totals_restore();
		write_register(REG_PION_MASS, RST_PION_MASS);
		write_register(REG_PROTON_MASS, RST_PROTON_MASS);
		write_register(REG_KAON_REF, RST_KAON_REF);
		write_register(REG_LAMBDA_REF, RST_LAMBDA_REF);
		write_register(REG_WIN_LOW, RST_WIN_LOW);
		write_register(REG_WIN_HIGH, RST_WIN_HIGH);
		repeat (10) send_pair();
		wait_drained();
	endtask

	initial begin
		m_pion = RST_PION_MASS; m_proton = RST_PROTON_MASS;
		ref_kaon = RST_KAON_REF; ref_lambda = RST_LAMBDA_REF;
		win_lo = RST_WIN_LOW; win_hi = RST_WIN_HIGH;
		acc_mass = 0; acc_square = 0;
		clear_event_sums();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_settings();
		test_totals_restore();
		$display("Sent %0d products closing %0d events, %0d masses accepted.",
			items_sent, events_seen, accepted_seen);
		if (errors == 0) $display("TEST PASSED");
		else $display("TEST FAILED");
		$finish;
	end

	initial begin
		#40ms;
		$display("TEST FAILED");
		$finish;
	end
endmodule
